// ----- rtl/alss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package alss_pkg;

  // entries in the store; port widths are sized for this depth
  localparam int DEPTH = 64;

  typedef enum logic [3:0] {
    KIND_PUSH_BACK  = 4'd0,
    KIND_POP_BACK   = 4'd1,
    KIND_PUSH_FRONT = 4'd2,
    KIND_POP_FRONT  = 4'd3,
    KIND_INSERT     = 4'd4,
    KIND_ERASE      = 4'd5,
    KIND_MODIFY     = 4'd6,
    KIND_SORT       = 4'd7,
    KIND_FIND       = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_SHUP  = 3'd1,
    OP_SHDN  = 3'd2,
    OP_WRITE = 3'd3,
    OP_SORTE = 3'd4,
    OP_SORTO = 3'd5
  } cell_op_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SORT   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/array_list_sort_search_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                        Transfer
// input     start, busy, in_kind, in_index, in_value     start & !busy
// result    out_valid, out_status/found/position/count   out_valid, one cycle
// Push, pop, insert, erase, modify: the cell row shifts or writes as the item is taken.
// Sort: odd-even transposition passes over the cell row.
// Find: as sort, then the halving steps of a binary search and a check of the hit.
// Synchronous active-low reset clears the count and control; entries are not cleared.
// The receiver cannot stall; busy stays high until the result cycle ends.
module array_list_sort_search_top
  import alss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_kind,
  input  wire logic [5:0]  in_index,
  input  wire logic signed [31:0] in_value,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_found,
  output logic [5:0]       out_position,
  output logic [6:0]       out_count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      pass_r, pass_nxt;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [31:0] key_r;
  logic               find_r;
  logic [1:0]         status_r, status_nxt;
  logic               found_r, found_nxt;
  logic [5:0]         pos_r, pos_nxt;

  cell_op_t           op;
  logic [CW-1:0]      gap_pos;
  logic [CW-1:0]      wr_pos;
  logic signed [31:0] vals [DEPTH];
  logic               accept;
  logic [CW:0]        in_idx_w;
  logic [CW-1:0]      mid;
  logic signed [31:0] mid_val;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign in_idx_w = (CW+1)'(in_index);

  // build the cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] below, above;
    logic par;
    if (g == 0) begin : g_b0
      assign below = vals[g];
    end else begin : g_b
      assign below = vals[g-1];
    end
    if (g == DEPTH-1) begin : g_at
      assign above = vals[g];
    end else begin : g_a
      assign above = vals[g+1];
    end
    assign par = (op == OP_SORTO);
    alss_cell u_cell (
      .clk       (clk),
      .op        (op),
      .sel_shift ((op == OP_SHUP) ? (CW'(g) > gap_pos && CW'(g) <= cnt_r)
                                  : (CW'(g) >= gap_pos && CW'(g) + 1'b1 < cnt_r)),
      .sel_write (CW'(g) == wr_pos),
      .pair_lo   ((g % 2 == 0) != par && CW'(g) + 1'b1 < cnt_r),
      .pair_hi   ((g % 2 == 1) != par && CW'(g) < cnt_r && g > 0),
      .wr_val    (in_value),
      .below_val (below),
      .above_val (above),
      .val_r     (vals[g])
    );
  end

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign mid_val = vals[mid[AW-1:0]];

  // decode the item, sequence sort and search
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pass_nxt   = pass_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    pos_nxt    = pos_r;
    op         = OP_HOLD;
    gap_pos    = '0;
    wr_pos     = {CW{1'b1}};
    case (state_r)
      S_IDLE: if (start) begin
        status_nxt = ST_OK;
        found_nxt  = 1'b0;
        pos_nxt    = '0;
        state_nxt  = S_DONE;
        case (in_kind)
          KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_INSERT: begin
            if ({1'b0, cnt_r} >= (CW+1)'(DEPTH)) status_nxt = ST_FULL;
            else if (in_kind == KIND_INSERT && in_idx_w > {1'b0, cnt_r})
              status_nxt = ST_RANGE;
            else begin
              op = OP_SHUP;
              gap_pos = (in_kind == KIND_PUSH_BACK) ? cnt_r :
                        (in_kind == KIND_PUSH_FRONT) ? '0 : in_idx_w[CW-1:0];
              wr_pos  = gap_pos;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          KIND_POP_BACK, KIND_POP_FRONT, KIND_ERASE, KIND_MODIFY: begin
            if (cnt_r == '0) status_nxt = ST_EMPTY;
            else if ((in_kind == KIND_ERASE || in_kind == KIND_MODIFY) &&
                     in_idx_w >= {1'b0, cnt_r}) status_nxt = ST_RANGE;
            else if (in_kind == KIND_MODIFY) begin
              op = OP_WRITE;
              wr_pos = in_idx_w[CW-1:0];
            end else begin
              op = OP_SHDN;
              gap_pos = (in_kind == KIND_POP_BACK) ? cnt_r - 1'b1 :
                        (in_kind == KIND_POP_FRONT) ? '0 : in_idx_w[CW-1:0];
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          KIND_SORT, KIND_FIND: begin
            state_nxt = S_SORT;
            pass_nxt  = '0;
          end
          default: ;
        endcase
      end
      S_SORT: begin
        // odd-even transposition: count passes sort the row
        op = pass_r[0] ? OP_SORTO : OP_SORTE;
        pass_nxt = pass_r + 1'b1;
        if (pass_r + 1'b1 >= cnt_r) begin
          pass_nxt = pass_r;
          lo_nxt = '0;
          hi_nxt = cnt_r;
          state_nxt = find_r ? S_SEARCH : S_DONE;
          if (cnt_r <= 1) op = OP_HOLD;
        end
      end
      S_SEARCH: begin
        if (lo_r < hi_r) begin
          if (mid_val < key_r) lo_nxt = mid + 1'b1;
          else hi_nxt = mid;
        end else begin
          state_nxt = S_DONE;
          if (lo_r < cnt_r && vals[lo_r[AW-1:0]] == key_r) begin
            found_nxt = 1'b1;
            pos_nxt   = 6'(lo_r);
          end
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r   <= pass_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    pos_r    <= pos_nxt;
    if (accept) begin
      key_r  <= in_value;
      find_r <= (in_kind == KIND_FIND);
    end
  end

  assign out_valid    = (state_r == S_DONE);
  assign out_status   = status_r;
  assign out_found    = found_r;
  assign out_position = pos_r;
  assign out_count    = 7'(cnt_r);
endmodule
`default_nettype wire

// ----- rtl/alss_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One entry slot; takes neighbors' values to shift, write or compare-swap.
module alss_cell
  import alss_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_op_t           op,
  input  wire logic               sel_shift,   // cell in the shifting span: above the gap (up) or at/above it (down)
  input  wire logic               sel_write,   // this cell is the write target
  input  wire logic               pair_lo,     // lower member of active pair
  input  wire logic               pair_hi,     // upper member of active pair
  input  wire logic signed [31:0] wr_val,
  input  wire logic signed [31:0] below_val,
  input  wire logic signed [31:0] above_val,
  output logic signed [31:0]      val_r
);
  logic signed [31:0] val_nxt;

  // pick next content from own, neighbor or write data
  always_comb begin
    val_nxt = val_r;
    case (op)
      OP_SHUP:  if (sel_write) val_nxt = wr_val;
                else if (sel_shift) val_nxt = below_val;
      OP_SHDN:  if (sel_shift) val_nxt = above_val;
      OP_WRITE: if (sel_write) val_nxt = wr_val;
      OP_SORTE, OP_SORTO: begin
        if (pair_lo && above_val < val_r) val_nxt = above_val;
        else if (pair_hi && val_r < below_val) val_nxt = below_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import alss_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 1800;

  // one expected result
  typedef struct {
    status_t    status;
    logic       found;
    logic [5:0] position;
    logic [6:0] count;
  } list_result_t;

  // models the list store and keeps the results still owed by the block
  class list_scoreboard;
    logic signed [31:0] store[DEPTH];
    int                 live;
    list_result_t       pending[$];
    int                 errors;

    function new();
      live = 0;
      errors = 0;
    endfunction

    function void sort_store();
      logic signed [31:0] key;
      int j;
      for (int i = 1; i < live; i++) begin
        key = store[i];
        j = i;
        while (j > 0 && key < store[j-1]) begin
          store[j] = store[j-1];
          j--;
        end
        store[j] = key;
      end
    endfunction

    function void open_gap(int pos, logic signed [31:0] v);
      for (int i = live; i > pos; i--) store[i] = store[i-1];
      store[pos] = v;
      live++;
    endfunction

    function void close_gap(int pos);
      for (int i = pos + 1; i < live; i++) store[i-1] = store[i];
      live--;
    endfunction

    // apply one accepted command and queue its expected result
    function void note_transfer(logic [3:0] kind, logic [5:0] idx, logic signed [31:0] v);
      list_result_t r;
      int lo, hi, mid;
      r.status = ST_OK;
      r.found = 1'b0;
      r.position = '0;
      case (kind)
        KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
          if (live >= DEPTH) r.status = ST_FULL;
          else open_gap(kind == KIND_PUSH_BACK ? live : 0, v);
        end
        KIND_POP_BACK, KIND_POP_FRONT: begin
          if (live == 0) r.status = ST_EMPTY;
          else close_gap(kind == KIND_POP_BACK ? live - 1 : 0);
        end
        KIND_INSERT: begin
          if (live >= DEPTH) r.status = ST_FULL;
          else if (idx > live) r.status = ST_RANGE;
          else open_gap(idx, v);
        end
        KIND_ERASE, KIND_MODIFY: begin
          if (live == 0) r.status = ST_EMPTY;
          else if (idx >= live) r.status = ST_RANGE;
          else if (kind == KIND_ERASE) close_gap(idx);
          else store[idx] = v;
        end
        KIND_SORT: sort_store();
        KIND_FIND: begin
          sort_store();
          lo = 0;
          hi = live;
          while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (store[mid] < v) lo = mid + 1;
            else hi = mid;
          end
          if (lo < live && store[lo] == v) begin
            r.found = 1'b1;
            r.position = lo[5:0];
          end
        end
        default: ;
      endcase
      r.count = live[6:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic fd, logic [5:0] pos, logic [6:0] cnt);
      list_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d found %0d pos %0d count %0d",
                 $time, st, fd, pos, cnt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (fd !== e.found) begin
        $display("%0t: found expected %0d actual %0d", $time, e.found, fd);
        errors++;
      end
      if (pos !== e.position) begin
        $display("%0t: position expected %0d actual %0d", $time, e.position, pos);
        errors++;
      end
      if (cnt !== e.count) begin
        $display("%0t: count expected %0d actual %0d", $time, e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_kind = '0;
  logic [5:0]  in_index = '0;
  logic signed [31:0] in_value = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_found;
  logic [5:0]  out_position;
  logic [6:0]  out_count;

  list_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  always #1 clk = ~clk;

  array_list_sort_search_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_index(in_index), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status), .out_found(out_found),
    .out_position(out_position), .out_count(out_count)
  );

  // check each result transfer; count cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_status, out_found, out_position, out_count);
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // drive one command and hold it until the block takes it
  task automatic send_cmd(logic [3:0] kind, logic [5:0] idx, logic signed [31:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_kind <= kind;
    in_index <= idx;
    in_value <= v;
    do @(posedge clk); while (busy);
    sb.note_transfer(kind, idx, v);
  endtask

  // drop start and wait until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom));
      default: return $signed(32'($urandom_range(0, 15)) - 32'sd8);
    endcase
  endfunction

  // random command; fill_bias favors growth of the store
  task automatic random_cmd(int fill_bias);
    logic [3:0] kind;
    logic [5:0] idx;
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) kind = 4'($urandom_range(9, 15));
    else if (r < fill_bias) kind = ($urandom_range(0, 1) == 0) ? KIND_PUSH_BACK : KIND_INSERT;
    else kind = 4'($urandom_range(0, 8));
    if ($urandom_range(0, 9) == 0) idx = 6'($urandom);
    else idx = 6'($urandom_range(0, sb.live));
    if (kind == KIND_PUSH_FRONT && $urandom_range(0, 1) == 0) kind = KIND_PUSH_BACK;
    send_cmd(kind, idx, pick_value());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-store errors, extremes, every kind
    send_cmd(KIND_POP_BACK, 6'd0, 32'sd0);
    send_cmd(KIND_POP_FRONT, 6'd0, 32'sd0);
    send_cmd(KIND_ERASE, 6'd0, 32'sd0);
    send_cmd(KIND_MODIFY, 6'd0, 32'sd0);
    send_cmd(KIND_FIND, 6'd0, 32'sd5);
    send_cmd(KIND_SORT, 6'd0, 32'sd0);
    send_cmd(KIND_INSERT, 6'd1, 32'sd3);
    send_cmd(KIND_PUSH_BACK, 6'd0, 32'sh7fff_ffff);
    send_cmd(KIND_SORT, 6'd0, 32'sd0);
    send_cmd(KIND_PUSH_FRONT, 6'd0, 32'sh8000_0000);
    send_cmd(KIND_INSERT, 6'd2, -32'sd1);
    send_cmd(KIND_INSERT, 6'd1, -32'sd1);
    send_cmd(KIND_MODIFY, 6'd0, 32'sd0);
    send_cmd(KIND_ERASE, 6'd4, 32'sd0);
    send_cmd(KIND_MODIFY, 6'd63, 32'sd0);
    send_cmd(KIND_INSERT, 6'd63, 32'sd0);
    send_cmd(KIND_FIND, 6'd0, -32'sd1);
    send_cmd(KIND_FIND, 6'd0, 32'sd2);
    send_cmd(KIND_ERASE, 6'd1, 32'sd0);
    send_cmd(4'd15, 6'd63, 32'shffff_ffff);
    send_cmd(4'd9, 6'd0, 32'sd0);
    send_cmd(KIND_POP_FRONT, 6'd0, 32'sd0);
    send_cmd(KIND_POP_BACK, 6'd0, 32'sd0);

    // hold until all results are back
    drain();

    // random phases: balanced, then fill to full, then drain to empty
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 600 < 300) random_cmd(20);
      else if (n % 600 < 450) random_cmd(80);
      else if ($urandom_range(0, 3) != 0)
        send_cmd(($urandom_range(0, 1) == 0) ? KIND_POP_BACK : KIND_ERASE,
                 6'($urandom_range(0, 63)), 32'sd0);
      else random_cmd(0);
      if (n == 900) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
